### hdl/sfd_pkg.sv
// Shared types, widths, codes and helpers for the stereo feedback delay.
// Used by every module and interface in hdl/ but sfd_ram; depends on nothing else.
package sfd_pkg;

  // Ring and sample geometry.
  localparam int RING_DEPTH  = 131072;
  localparam int SAMPLE_BITS = 24;
  localparam int IDX_W       = $clog2(RING_DEPTH);

  // Register and field widths fixed by the block's definition.
  localparam int DL_W       = 17;
  localparam int COEF_W     = 16;
  localparam int RAMP_W     = 16;
  localparam int TGT_W      = 17;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  // Fixed-point formats.
  localparam int DAMP_FRAC = 8;
  localparam int DAMP_W    = SAMPLE_BITS + DAMP_FRAC;
  localparam int DIFF_W    = DAMP_W + 1;
  localparam int WET_FRAC  = 31;
  localparam int WET_W     = WET_FRAC + 2;
  localparam int TGT_SHIFT = WET_FRAC - 16;
  localparam int FB_SHIFT  = DAMP_FRAC + COEF_W;
  localparam int SUM_W     = SAMPLE_BITS + 2;
  localparam int CMP_W     = (DL_W > IDX_W + 1) ? DL_W : IDX_W + 1;

  // Shared multiplier operand widths.
  localparam int MUL_A_W = (DIFF_W > WET_W) ? DIFF_W : WET_W;
  localparam int MUL_B_W = (SAMPLE_BITS > COEF_W + 1) ? SAMPLE_BITS : COEF_W + 1;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  localparam logic signed [MUL_P_W-1:0] FB_RND  = MUL_P_W'(64'd1 << (FB_SHIFT - 1));
  localparam logic signed [MUL_P_W-1:0] WET_RND = MUL_P_W'(64'd1 << (WET_FRAC - 1));

  // Divider geometry: magnitude of the ramp span over the ramp length.
  localparam int DVD_W     = WET_FRAC + 1;
  localparam int DVS_W     = RAMP_W;
  localparam int DIV_CNT_W = $clog2(DVD_W + 1);

  localparam logic [TGT_W-1:0] WET_ONE = TGT_W'(65536);

  // Register reset values.
  localparam logic [DL_W-1:0]   DL_RESET   = DL_W'(24000);
  localparam logic [COEF_W-1:0] FB_RESET   = COEF_W'(32768);
  localparam logic [COEF_W-1:0] DAMP_RESET = COEF_W'(32768);
  localparam logic [RAMP_W-1:0] RAMP_RESET = RAMP_W'(960);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DELAY    = 3'd0,
    CFG_FEEDBACK = 3'd1,
    CFG_DAMP     = 3'd2,
    CFG_PINGPONG = 3'd3,
    CFG_STEREO   = 3'd4,
    CFG_RAMP     = 3'd5
  } sfd_cfg_e;

  typedef enum logic [1:0] {
    MOP_DAMP,
    MOP_FB,
    MOP_WET
  } sfd_mop_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TARGET,
    ST_DIVIDE,
    ST_DECIDE,
    ST_DAMP_L,
    ST_DAMP_R,
    ST_FB_L,
    ST_FB_R,
    ST_WET_L,
    ST_WET_R,
    ST_FINISH,
    ST_PUSH
  } sfd_state_e;

  typedef struct packed {
    sfd_mop_e                   op;
    logic signed [MUL_A_W-1:0]  a;
    logic signed [MUL_B_W-1:0]  b;
  } mul_req_t;

  typedef struct packed {
    logic              start;
    logic [DVD_W-1:0]  dividend;
    logic [DVS_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DVD_W-1:0]  quotient;
  } div_rsp_t;

  // Clamp a widened sum to the signed sample range.
  function automatic sample_t sat_sample(input logic signed [SUM_W-1:0] x);
    logic same;
    sample_t r;
    same = (x[SUM_W-1:SAMPLE_BITS-1] == '0) || (x[SUM_W-1:SAMPLE_BITS-1] == '1);
    if (same) begin
      r = x[SAMPLE_BITS-1:0];
    end else if (x[SUM_W-1]) begin
      r = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      r = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

### hdl/sfd_if.sv
// Valid/ready stream interfaces for the input frames and the result frames.
// Depends on sfd_pkg for the sample type and field widths.
interface sfd_in_if;
  import sfd_pkg::*;
  logic              valid;
  logic              ready;
  sample_t           left_in;
  sample_t           right_in;
  logic [TGT_W-1:0]  wet_target;
  modport source (output valid, left_in, right_in, wet_target, input ready);
  modport sink (input valid, left_in, right_in, wet_target, output ready);
endinterface

interface sfd_out_if;
  import sfd_pkg::*;
  logic     valid;
  logic     ready;
  sample_t  left_out;
  sample_t  right_out;
  modport source (output valid, left_out, right_out, input ready);
  modport sink (input valid, left_out, right_out, output ready);
endinterface

### hdl/stereo_feedback_delay.sv
// Top level of the stereo feedback delay: sequencer, datapath registers,
// delay rings, shared multiplier and ramp divider. Depends on sfd_pkg,
// sfd_if, sfd_ram, sfd_mul and sfd_div.
//
//   Channel   Direction  Handshake            Payload
//   frame_i   in         valid / ready        left_in, right_in, wet_target
//   frame_o   out        valid / ready        left_out, right_out
//   cfg       in         cfg_we_i (no wait)   cfg_idx_i, cfg_data_i
//
// Bypassed frames pass through untouched. When the delay is active, the six
// products of a frame (two damper updates, two feedback terms, two wet
// terms) go one per cycle through the single shared multiplier. A frame
// whose wet target differs from the held one waits, if the ramp length is
// nonzero, while the bit-serial divider works out the ramp step. Reset is
// asynchronous and active low; the rings need no clearing pass, since a
// write mark makes unwritten entries read as zero. A stalled result waits
// in the output register while the next frame is taken.
module stereo_feedback_delay (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [sfd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sfd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  sfd_in_if.sink                         frame_i,
  sfd_out_if.source                      frame_o
);
  import sfd_pkg::*;

  // Configuration registers.
  logic [DL_W-1:0]   dl_cfg_q;
  logic [COEF_W-1:0] fb_gain_q;
  logic [COEF_W-1:0] damp_coef_q;
  logic              pingpong_q;
  logic              stereo_q;
  logic [RAMP_W-1:0] ramp_len_q;

  // Sequencer.
  sfd_state_e state_q, state_d;

  // Frame and ramp state.
  sample_t                 in_l_q, in_l_d, in_r_q, in_r_d;
  logic [TGT_W-1:0]        tgt_q, tgt_d, held_q, held_d;
  logic [RAMP_W-1:0]       ramp_left_q, ramp_left_d;
  logic signed [WET_W-1:0] wet_now_q, wet_now_d, wet_inc_q, wet_inc_d;
  logic                    div_neg_q, div_neg_d;

  // Ring and damper state. The rings are written strictly in order from
  // index zero after a flush, so entries below the write index, or all of
  // them once the index has wrapped, hold real data.
  logic [IDX_W-1:0]         wi_q, wi_d;
  logic                     full_q, full_d;
  logic                     flushed_q, flushed_d;
  logic signed [DAMP_W-1:0] damp_l_q, damp_l_d, damp_r_q, damp_r_d;
  logic                     tap_ok_q, tap_ok_d;

  // Results.
  sample_t res_l_q, res_l_d, res_r_q, res_r_d;
  sample_t out_l_q, out_l_d, out_r_q, out_r_d;
  logic    ov_q, ov_d;

  // Unit connections.
  mul_req_t                  mul_req;
  logic signed [MUL_P_W-1:0] mul_res;
  div_req_t                  div_req;
  div_rsp_t                  div_rsp;
  logic                      ram_re, ram_we_l, ram_we_r;
  logic [IDX_W-1:0]          rd_addr;
  sample_t                   wdata_l, wdata_r;
  logic [SAMPLE_BITS-1:0]    rdata_l, rdata_r;

  // Derived values.
  logic                     pp_mode, bypass, tgt_new, wrap;
  logic [CMP_W-1:0]         dl_ext;
  logic [IDX_W-1:0]         dl_eff;
  logic [IDX_W:0]           rd_wide;
  logic [TGT_W-1:0]         tgt_clamped;
  logic signed [WET_W-1:0]  tgt_wide, held_wide, tgt_diff, tgt_mag;
  sample_t                  tap_l, tap_r, x_l, x_r;
  logic signed [DIFF_W-1:0] diff_l, diff_r;
  logic signed [SUM_W-1:0]  sum_in_l, sum_in_r;

  // ---------------------------------------------------------------------
  // Configuration port. Writes beyond the register list are dropped.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dl_cfg_q    <= DL_RESET;
      fb_gain_q   <= FB_RESET;
      damp_coef_q <= DAMP_RESET;
      pingpong_q  <= 1'b0;
      stereo_q    <= 1'b1;
      ramp_len_q  <= RAMP_RESET;
    end else if (cfg_we_i) begin
      case (sfd_cfg_e'(cfg_idx_i))
        CFG_DELAY:    dl_cfg_q    <= cfg_data_i[DL_W-1:0];
        CFG_FEEDBACK: fb_gain_q   <= cfg_data_i[COEF_W-1:0];
        CFG_DAMP:     damp_coef_q <= cfg_data_i[COEF_W-1:0];
        CFG_PINGPONG: pingpong_q  <= cfg_data_i[0];
        CFG_STEREO:   stereo_q    <= cfg_data_i[0];
        CFG_RAMP:     ramp_len_q  <= cfg_data_i[RAMP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Derived values.
  // ---------------------------------------------------------------------
  always_comb begin
    pp_mode     = stereo_q && pingpong_q;
    tgt_new     = (tgt_q != held_q);
    bypass      = (tgt_q == '0) && (ramp_left_q == '0);
    tgt_clamped = (frame_i.wet_target > WET_ONE) ? WET_ONE : frame_i.wet_target;
    tgt_wide    = WET_W'({tgt_q, {TGT_SHIFT{1'b0}}});
    held_wide   = WET_W'({held_q, {TGT_SHIFT{1'b0}}});
    tgt_diff    = tgt_wide - wet_now_q;
    tgt_mag     = tgt_diff[WET_W-1] ? -tgt_diff : tgt_diff;

    // Delay clamped to one through the ring depth less one.
    dl_ext = CMP_W'(dl_cfg_q);
    if (dl_cfg_q == '0) begin
      dl_eff = IDX_W'(1);
    end else if (dl_ext > CMP_W'(RING_DEPTH - 1)) begin
      dl_eff = IDX_W'(RING_DEPTH - 1);
    end else begin
      dl_eff = dl_ext[IDX_W-1:0];
    end
    rd_wide = {1'b0, wi_q} - {1'b0, dl_eff};
    rd_addr = rd_wide[IDX_W] ? IDX_W'(rd_wide + (IDX_W + 1)'(RING_DEPTH))
                             : rd_wide[IDX_W-1:0];
    wrap = (wi_q == IDX_W'(RING_DEPTH - 1));

    // Taps from entries never written since the last flush read as zero.
    tap_l = tap_ok_q ? sample_t'(rdata_l) : '0;
    tap_r = tap_ok_q ? sample_t'(rdata_r) : '0;
    x_l   = pp_mode ? tap_r : tap_l;
    x_r   = pp_mode ? tap_l : tap_r;
    diff_l = ({{(DIFF_W - SAMPLE_BITS){x_l[SAMPLE_BITS-1]}}, x_l} <<< DAMP_FRAC)
             - DIFF_W'(damp_l_q);
    diff_r = ({{(DIFF_W - SAMPLE_BITS){x_r[SAMPLE_BITS-1]}}, x_r} <<< DAMP_FRAC)
             - DIFF_W'(damp_r_q);

    // The multiplier result is always within SUM_W here.
    sum_in_l = SUM_W'(in_l_q) + $signed(mul_res[SUM_W-1:0]);
    sum_in_r = SUM_W'(in_r_q) + $signed(mul_res[SUM_W-1:0]);
  end

  // ---------------------------------------------------------------------
  // Sequencer: next state.
  // ---------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (frame_i.valid) state_d = ST_TARGET;
      ST_TARGET: state_d = (tgt_new && (ramp_len_q != '0)) ? ST_DIVIDE : ST_DECIDE;
      ST_DIVIDE: if (div_rsp.done) state_d = ST_DECIDE;
      ST_DECIDE: state_d = bypass ? ST_PUSH : ST_DAMP_L;
      ST_DAMP_L: state_d = ST_DAMP_R;
      ST_DAMP_R: state_d = ST_FB_L;
      ST_FB_L:   state_d = ST_FB_R;
      ST_FB_R:   state_d = ST_WET_L;
      ST_WET_L:  state_d = ST_WET_R;
      ST_WET_R:  state_d = ST_FINISH;
      ST_FINISH: state_d = ST_PUSH;
      ST_PUSH:   if (!ov_q || frame_o.ready) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------
  // Sequencer: unit and memory controls. Each product issued in one state
  // comes back from the multiplier in the state that follows.
  // ---------------------------------------------------------------------
  always_comb begin
    frame_i.ready = (state_q == ST_IDLE);

    div_req.start    = (state_q == ST_TARGET) && tgt_new && (ramp_len_q != '0);
    div_req.dividend = tgt_mag[DVD_W-1:0];
    div_req.divisor  = ramp_len_q;

    ram_re   = (state_q == ST_DECIDE);
    ram_we_l = (state_q == ST_FB_R);
    wdata_l  = sat_sample(sum_in_l);
    // In mono the right ring only gets zeros written ahead of the write mark,
    // which keeps its data in step with the left ring's mark.
    ram_we_r = (state_q == ST_WET_L) && (stereo_q || !full_q);
    wdata_r  = stereo_q ? sat_sample(sum_in_r) : '0;

    mul_req.op = MOP_DAMP;
    mul_req.a  = '0;
    mul_req.b  = '0;
    case (state_q)
      ST_DAMP_L: begin
        mul_req.op = MOP_DAMP;
        mul_req.a  = MUL_A_W'(diff_l);
        mul_req.b  = MUL_B_W'(damp_coef_q);
      end
      ST_DAMP_R: begin
        mul_req.op = MOP_DAMP;
        mul_req.a  = MUL_A_W'(diff_r);
        mul_req.b  = MUL_B_W'(damp_coef_q);
      end
      ST_FB_L: begin
        mul_req.op = MOP_FB;
        mul_req.a  = MUL_A_W'(damp_l_q);
        mul_req.b  = MUL_B_W'(fb_gain_q);
      end
      ST_FB_R: begin
        mul_req.op = MOP_FB;
        mul_req.a  = MUL_A_W'(damp_r_q);
        mul_req.b  = MUL_B_W'(fb_gain_q);
      end
      ST_WET_L: begin
        mul_req.op = MOP_WET;
        mul_req.a  = MUL_A_W'(wet_now_q);
        mul_req.b  = MUL_B_W'(tap_l);
      end
      ST_WET_R: begin
        mul_req.op = MOP_WET;
        mul_req.a  = MUL_A_W'(wet_now_q);
        mul_req.b  = MUL_B_W'(tap_r);
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // Datapath next values.
  // ---------------------------------------------------------------------
  always_comb begin
    in_l_d      = in_l_q;
    in_r_d      = in_r_q;
    tgt_d       = tgt_q;
    held_d      = held_q;
    ramp_left_d = ramp_left_q;
    wet_now_d   = wet_now_q;
    wet_inc_d   = wet_inc_q;
    div_neg_d   = div_neg_q;
    wi_d        = wi_q;
    full_d      = full_q;
    flushed_d   = flushed_q;
    damp_l_d    = damp_l_q;
    damp_r_d    = damp_r_q;
    tap_ok_d    = tap_ok_q;
    res_l_d     = res_l_q;
    res_r_d     = res_r_q;
    out_l_d     = out_l_q;
    out_r_d     = out_r_q;
    ov_d        = (ov_q && frame_o.ready) ? 1'b0 : ov_q;

    case (state_q)
      ST_IDLE: begin
        if (frame_i.valid) begin
          in_l_d = frame_i.left_in;
          in_r_d = frame_i.right_in;
          tgt_d  = tgt_clamped;
        end
      end
      ST_TARGET: begin
        // A changed target starts a new ramp, or jumps when the length is 0.
        if (tgt_new) begin
          held_d = tgt_q;
          if (ramp_len_q == '0) begin
            wet_now_d   = tgt_wide;
            ramp_left_d = '0;
          end else begin
            ramp_left_d = ramp_len_q;
            div_neg_d   = tgt_diff[WET_W-1];
          end
        end
      end
      ST_DIVIDE: begin
        // Truncating division: divide the magnitude, then restore the sign.
        if (div_rsp.done) begin
          wet_inc_d = div_neg_q ? -WET_W'(div_rsp.quotient) : WET_W'(div_rsp.quotient);
        end
      end
      ST_DECIDE: begin
        if (bypass) begin
          // Pass the frame through and clear the delay once.
          wet_now_d = '0;
          res_l_d   = in_l_q;
          res_r_d   = in_r_q;
          if (!flushed_q) begin
            wi_d      = '0;
            full_d    = 1'b0;
            damp_l_d  = '0;
            damp_r_d  = '0;
            flushed_d = 1'b1;
          end
        end else begin
          flushed_d = 1'b0;
          if (ramp_left_q != '0) begin
            ramp_left_d = ramp_left_q - 1'b1;
            // The last step of a ramp lands exactly on the target.
            wet_now_d = (ramp_left_q == RAMP_W'(1)) ? held_wide : wet_now_q + wet_inc_q;
          end
          tap_ok_d = full_q || (rd_addr < wi_q);
        end
      end
      ST_DAMP_R: begin
        damp_l_d = DAMP_W'(DIFF_W'(damp_l_q) + $signed(mul_res[DIFF_W-1:0]));
      end
      ST_FB_L: begin
        if (stereo_q) begin
          damp_r_d = DAMP_W'(DIFF_W'(damp_r_q) + $signed(mul_res[DIFF_W-1:0]));
        end
      end
      ST_WET_R: begin
        res_l_d = sat_sample(sum_in_l);
      end
      ST_FINISH: begin
        res_r_d = stereo_q ? sat_sample(sum_in_r) : in_r_q;
        wi_d    = wrap ? '0 : wi_q + 1'b1;
        if (wrap) begin
          full_d = 1'b1;
        end
      end
      ST_PUSH: begin
        if (!ov_q || frame_o.ready) begin
          out_l_d = res_l_q;
          out_r_d = res_r_q;
          ov_d    = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // Registers.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      held_q      <= '0;
      ramp_left_q <= '0;
      wet_now_q   <= '0;
      wet_inc_q   <= '0;
      wi_q        <= '0;
      full_q      <= 1'b0;
      flushed_q   <= 1'b1;
      damp_l_q    <= '0;
      damp_r_q    <= '0;
      tap_ok_q    <= 1'b0;
      ov_q        <= 1'b0;
    end else begin
      state_q     <= state_d;
      held_q      <= held_d;
      ramp_left_q <= ramp_left_d;
      wet_now_q   <= wet_now_d;
      wet_inc_q   <= wet_inc_d;
      wi_q        <= wi_d;
      full_q      <= full_d;
      flushed_q   <= flushed_d;
      damp_l_q    <= damp_l_d;
      damp_r_q    <= damp_r_d;
      tap_ok_q    <= tap_ok_d;
      ov_q        <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_l_q    <= in_l_d;
    in_r_q    <= in_r_d;
    tgt_q     <= tgt_d;
    div_neg_q <= div_neg_d;
    res_l_q   <= res_l_d;
    res_r_q   <= res_r_d;
    out_l_q   <= out_l_d;
    out_r_q   <= out_r_d;
  end

  assign frame_o.valid     = ov_q;
  assign frame_o.left_out  = out_l_q;
  assign frame_o.right_out = out_r_q;

  // ---------------------------------------------------------------------
  // Units.
  // ---------------------------------------------------------------------
  sfd_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (RING_DEPTH)
  ) u_ring_l (
    .clk_i   (clk_i),
    .we_i    (ram_we_l),
    .waddr_i (wi_q),
    .wdata_i (wdata_l),
    .re_i    (ram_re),
    .raddr_i (rd_addr),
    .rdata_o (rdata_l)
  );

  sfd_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (RING_DEPTH)
  ) u_ring_r (
    .clk_i   (clk_i),
    .we_i    (ram_we_r),
    .waddr_i (wi_q),
    .wdata_i (wdata_r),
    .re_i    (ram_re),
    .raddr_i (rd_addr),
    .rdata_o (rdata_r)
  );

  sfd_mul u_mul (
    .clk_i (clk_i),
    .req_i (mul_req),
    .res_o (mul_res)
  );

  sfd_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

endmodule

### hdl/sfd_ram.sv
// Generic single-write, single-read RAM with a registered, enabled read port.
// Standalone; used for both delay rings.
module sfd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/sfd_mul.sv
// Shared signed multiplier with a registered product and a per-operation
// shift. Depends on sfd_pkg for operand widths and operation codes.
module sfd_mul (
  input  logic                               clk_i,
  input  sfd_pkg::mul_req_t                  req_i,
  output logic signed [sfd_pkg::MUL_P_W-1:0] res_o
);
  import sfd_pkg::*;

  logic signed [MUL_P_W-1:0] prod_q, prod_d;
  sfd_mop_e                  op_q;

  assign prod_d = $signed(req_i.a) * $signed(req_i.b);

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    op_q   <= req_i.op;
  end

  // The damper takes a floor shift; feedback and wet terms round half up.
  always_comb begin
    case (op_q)
      MOP_DAMP: res_o = prod_q >>> COEF_W;
      MOP_FB:   res_o = (prod_q + FB_RND) >>> FB_SHIFT;
      MOP_WET:  res_o = (prod_q + WET_RND) >>> WET_FRAC;
      default:  res_o = prod_q;
    endcase
  end

endmodule

### hdl/sfd_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on sfd_pkg for widths and the request and response structs.
module sfd_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sfd_pkg::div_req_t req_i,
  output sfd_pkg::div_rsp_t rsp_o
);
  import sfd_pkg::*;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DVS_W-1:0]     rem_q, rem_d;
  logic [DVS_W-1:0]     dvs_q, dvs_d;
  logic [DVD_W-1:0]     quo_q, quo_d;
  logic [DVS_W:0]       shifted;
  logic                 fits;

  always_comb begin
    shifted = {rem_q, quo_q[DVD_W-1]};
    fits    = (shifted >= {1'b0, dvs_q});
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    quo_d   = quo_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNT_W'(DVD_W);
      rem_d  = '0;
      dvs_d  = req_i.divisor;
      quo_d  = req_i.dividend;
    end else if (busy_q) begin
      rem_d = fits ? DVS_W'(shifted - {1'b0, dvs_q}) : shifted[DVS_W-1:0];
      quo_d = {quo_q[DVD_W-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule
